[rtl/bgd_pkg.sv]
// Shared types, constants and table functions for the bivariate Gaussian density block.
`default_nettype none

package bgd_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [29:0] INV2PI_Q32 = 30'd683565276;
    localparam logic [23:0] DENSITY_MAX = 24'hFF_FFFF;
    localparam logic [6:0]  EXP_SHIFT_LIMIT = 7'd40;

    typedef enum logic [2:0] {
        CFG_MEAN_X = 3'd0,
        CFG_MEAN_Y = 3'd1,
        CFG_VAR_X  = 3'd2,
        CFG_VAR_Y  = 3'd3,
        CFG_COV_XY = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
    } offs_t;

    typedef struct packed {
        logic signed [15:0] mean_x;
        logic signed [15:0] mean_y;
        logic [15:0]        var_x;
        logic [15:0]        var_y;
        logic signed [15:0] cov_xy;
        logic [31:0]        det;
        logic               det_pos;
        logic [23:0]        root;
    } cfg_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(32 - 2^-k) scale factors, Q.32
    function automatic logic [31:0] pow_tab(input int k);
        logic [63:0] t;
        t = 64'h8000_0000;
        for (int j = 1; j <= 16; j++) begin
            if (j <= k) begin
                t = isqrt64(t << 32);
            end
        end
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/bgd_cfg.sv]
// Configuration registers plus pipelined determinant of the covariance and its square root.
`default_nettype none

module bgd_cfg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output bgd_pkg::cfg_t      cfg
);

    logic signed [15:0] mean_x_reg, mean_y_reg, cov_xy_reg;
    logic [15:0]        var_x_reg, var_y_reg;
    logic [31:0]        pxx_reg;
    logic [30:0]        pcc_reg;
    logic signed [32:0] det_reg;
    logic signed [31:0] cc_full;
    logic [47:0]        rem_reg [0:24];
    logic [23:0]        rt_reg  [0:24];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_x_reg <= '0;
            mean_y_reg <= '0;
            var_x_reg  <= 16'd256;
            var_y_reg  <= 16'd256;
            cov_xy_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bgd_pkg::CFG_MEAN_X: mean_x_reg <= $signed(cfg_data);
                bgd_pkg::CFG_MEAN_Y: mean_y_reg <= $signed(cfg_data);
                bgd_pkg::CFG_VAR_X:  var_x_reg  <= cfg_data;
                bgd_pkg::CFG_VAR_Y:  var_y_reg  <= cfg_data;
                bgd_pkg::CFG_COV_XY: cov_xy_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    assign cc_full = cov_xy_reg * cov_xy_reg;

    always_ff @(posedge aclk) begin
        pxx_reg <= var_x_reg * var_y_reg;
        pcc_reg <= cc_full[30:0];
        det_reg <= $signed({1'b0, pxx_reg}) - $signed({2'b0, pcc_reg});
        rem_reg[0] <= {det_reg[31:0], 16'b0};
        rt_reg[0]  <= '0;
    end

    // one root bit per stage, msb first
    for (genvar i = 0; i < 24; i++) begin : g_sqrt
        localparam int BIT = 23 - i;
        logic [49:0] test;
        assign test = (50'(rt_reg[i]) << (BIT + 1)) + (50'(1) << (2 * BIT));
        always_ff @(posedge aclk) begin
            if (50'(rem_reg[i]) >= test) begin
                rem_reg[i+1] <= 48'(50'(rem_reg[i]) - test);
                rt_reg[i+1]  <= rt_reg[i] | (24'(1) << BIT);
            end else begin
                rem_reg[i+1] <= rem_reg[i];
                rt_reg[i+1]  <= rt_reg[i];
            end
        end
    end

    always_comb begin
        cfg.mean_x  = mean_x_reg;
        cfg.mean_y  = mean_y_reg;
        cfg.var_x   = var_x_reg;
        cfg.var_y   = var_y_reg;
        cfg.cov_xy  = cov_xy_reg;
        cfg.det     = det_reg[31:0];
        cfg.det_pos = !det_reg[32] && (det_reg != '0);
        cfg.root    = rt_reg[24];
    end

endmodule

`default_nettype wire

[rtl/bgd_front.sv]
// Input side: takes points and forms offsets from the mean.
`default_nettype none

module bgd_front (
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [31:0]   s_tdata,
    input  wire bgd_pkg::cfg_t cfg,
    input  wire logic          q_full,
    output logic               q_push,
    output bgd_pkg::offs_t     q_data
);

    logic signed [15:0] px, py;

    assign px       = $signed(s_tdata[15:0]);
    assign py       = $signed(s_tdata[31:16]);
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_data.dx = 17'(px) - 17'(cfg.mean_x);
        q_data.dy = 17'(py) - 17'(cfg.mean_y);
    end

endmodule

`default_nettype wire

[rtl/bgd_fifo.sv]
// Short queue of offset words between the front and the compute pipeline.
`default_nettype none

module bgd_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire bgd_pkg::offs_t push_data,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output bgd_pkg::offs_t      head
);

    bgd_pkg::offs_t                entries_reg [bgd_pkg::FIFO_DEPTH];
    logic [bgd_pkg::FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [bgd_pkg::FIFO_AW:0]     count_reg;

    assign full      = (count_reg == (bgd_pkg::FIFO_AW+1)'(bgd_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/bgd_back.sv]
// Compute pipeline: quadratic form, divide, exponential, scaling divide and output register.
`default_nettype none

module bgd_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire bgd_pkg::offs_t q_data,
    output logic                q_pop,
    input  wire bgd_pkg::cfg_t  cfg,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [23:0]         m_tdata,
    output logic                m_tuser
);

    logic adv;

    // quadratic form
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [33:0] sxx, syy;
    logic signed [32:0] sxy;
    logic [31:0]        dxx_reg, dyy_reg;
    logic signed [32:0] dxy_reg;
    logic [47:0]        a_reg, c_reg;
    logic signed [48:0] b_reg;
    logic signed [50:0] num;
    logic [49:0]        num_reg;
    logic [57:0]        dvd_reg;

    // h divider
    logic [53:0] dr_reg   [0:22];
    logic [21:0] dq_reg   [0:22];
    logic        dfar_reg [0:22];
    logic        dv_reg   [0:22];

    // exponential
    logic [53:0] tprod;
    logic [32:0] er_reg   [0:16];
    logic [15:0] ef_reg   [0:16];
    logic [6:0]  en_reg   [0:16];
    logic        efar_reg [0:16];
    logic        ev_reg   [0:16];
    logic [32:0] sh_reg;
    logic        sv_reg;
    logic [33:0] sh_round;
    logic [32:0] sh_val;

    // scaling divider
    logic [63:0] xprod;
    logic [35:0] y_reg;
    logic        yv_reg;
    logic [35:0] fr_reg   [0:24];
    logic [23:0] fq_reg   [0:24];
    logic        fsat_reg [0:24];
    logic        fv_reg   [0:24];

    logic               m_tvalid_reg;
    logic [23:0]        m_tdata_reg;
    logic               m_tuser_reg;

    assign adv   = !m_tvalid_reg || m_tready;
    assign q_pop = adv && q_valid;

    assign sxx = q_data.dx * q_data.dx;
    assign syy = q_data.dy * q_data.dy;
    assign sxy = q_data.dx * q_data.dy;
    assign num = $signed(51'(a_reg)) + $signed(51'(c_reg)) - ($signed(51'(b_reg)) <<< 1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            dxx_reg <= sxx[31:0];
            dyy_reg <= syy[31:0];
            dxy_reg <= sxy;
            a_reg   <= cfg.var_y * dxx_reg;
            c_reg   <= cfg.var_x * dyy_reg;
            b_reg   <= cfg.cov_xy * dxy_reg;
            num_reg <= num[50] ? '0 : num[49:0];
            dvd_reg <= {1'b0, num_reg, 7'b0} + 58'(cfg.det[31:1]);
            dr_reg[0]   <= dvd_reg[53:0];
            dq_reg[0]   <= '0;
            dfar_reg[0] <= (dvd_reg >= {4'b0, cfg.det, 22'b0});
        end
    end

    // one quotient bit per stage
    for (genvar i = 0; i < 22; i++) begin : g_hdiv
        localparam int BIT = 21 - i;
        logic [53:0] dsr;
        assign dsr = 54'(cfg.det) << BIT;
        always_ff @(posedge aclk) begin
            if (adv) begin
                dfar_reg[i+1] <= dfar_reg[i];
                if (dr_reg[i] >= dsr) begin
                    dr_reg[i+1] <= dr_reg[i] - dsr;
                    dq_reg[i+1] <= dq_reg[i] | (22'(1) << BIT);
                end else begin
                    dr_reg[i+1] <= dr_reg[i];
                    dq_reg[i+1] <= dq_reg[i];
                end
            end
        end
    end

    assign tprod = 54'(dq_reg[22]) * 54'(bgd_pkg::LOG2E_Q30) + (54'(1) << 29);

    always_ff @(posedge aclk) begin
        if (adv) begin
            er_reg[0]   <= 33'h1_0000_0000;
            ef_reg[0]   <= tprod[45:30];
            en_reg[0]   <= tprod[52:46];
            efar_reg[0] <= dfar_reg[22];
        end
    end

    // fraction bits of the exponent, msb first
    for (genvar k = 1; k <= 16; k++) begin : g_exp
        localparam logic [31:0] TK = bgd_pkg::pow_tab(k);
        logic [64:0] prod;
        assign prod = 65'(er_reg[k-1]) * 65'(TK) + (65'(1) << 31);
        always_ff @(posedge aclk) begin
            if (adv) begin
                ef_reg[k]   <= ef_reg[k-1];
                en_reg[k]   <= en_reg[k-1];
                efar_reg[k] <= efar_reg[k-1];
                er_reg[k]   <= ef_reg[k-1][16-k] ? prod[64:32] : er_reg[k-1];
            end
        end
    end

    always_comb begin
        sh_round = '0;
        if (efar_reg[16] || (en_reg[16] >= bgd_pkg::EXP_SHIFT_LIMIT)) begin
            sh_val = '0;
        end else if (en_reg[16] == '0) begin
            sh_val = er_reg[16];
        end else begin
            sh_round = 34'(er_reg[16]) + (34'(1) << (en_reg[16] - 7'd1));
            sh_val   = 33'(sh_round >> en_reg[16]);
        end
    end

    assign xprod = 64'(sh_reg) * 64'(bgd_pkg::INV2PI_Q32) + (64'(cfg.root) << 27);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sh_reg      <= sh_val;
            y_reg       <= xprod[63:28];
            fr_reg[0]   <= y_reg;
            fq_reg[0]   <= '0;
            fsat_reg[0] <= (48'(y_reg) >= {cfg.root, 24'b0});
        end
    end

    for (genvar i = 0; i < 24; i++) begin : g_fdiv
        localparam int BIT = 23 - i;
        logic [47:0] dsr;
        assign dsr = 48'(cfg.root) << BIT;
        always_ff @(posedge aclk) begin
            if (adv) begin
                fsat_reg[i+1] <= fsat_reg[i];
                if (48'(fr_reg[i]) >= dsr) begin
                    fr_reg[i+1] <= 36'(48'(fr_reg[i]) - dsr);
                    fq_reg[i+1] <= fq_reg[i] | (24'(1) << BIT);
                end else begin
                    fr_reg[i+1] <= fr_reg[i];
                    fq_reg[i+1] <= fq_reg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tuser_reg <= !cfg.det_pos;
            if (!cfg.det_pos) begin
                m_tdata_reg <= '0;
            end else if (fsat_reg[24]) begin
                m_tdata_reg <= bgd_pkg::DENSITY_MAX;
            end else begin
                m_tdata_reg <= fq_reg[24];
            end
        end
    end

    // word valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            sv_reg <= 1'b0;
            yv_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int j = 0; j <= 22; j++) dv_reg[j] <= 1'b0;
            for (int j = 0; j <= 16; j++) ev_reg[j] <= 1'b0;
            for (int j = 0; j <= 24; j++) fv_reg[j] <= 1'b0;
        end else if (adv) begin
            v1_reg    <= q_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int j = 1; j <= 22; j++) dv_reg[j] <= dv_reg[j-1];
            ev_reg[0] <= dv_reg[22];
            for (int j = 1; j <= 16; j++) ev_reg[j] <= ev_reg[j-1];
            sv_reg    <= ev_reg[16];
            yv_reg    <= sv_reg;
            fv_reg[0] <= yv_reg;
            for (int j = 1; j <= 24; j++) fv_reg[j] <= fv_reg[j-1];
            m_tvalid_reg <= fv_reg[24];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[rtl/bivariate_gaussian_density.sv]
// Top level of the bivariate Gaussian density evaluator.
//
// Takes one point per clock and returns one density word per point, in order, at one word per
// clock sustained while the result side takes every word. From acceptance a point passes a queue
// stage, the quadratic form registers, a 22-stage divide for q/2, 16 multiply stages of the
// exponential, and a 24-stage divide by the root of the determinant. The determinant and its
// square root are formed from the configuration registers by a free-running pipeline, which
// finishes long before a point accepted after a register write reaches the stages that use it.
// A stall on the result side holds the whole compute pipeline; the input queue keeps taking
// points until it holds four words.
`default_nettype none

module bivariate_gaussian_density (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] point_x, [31:16] point_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [23:0] density
    output logic             m_tuser,   // [0] invalid
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    bgd_pkg::cfg_t  cfg;
    bgd_pkg::offs_t push_data, head;
    logic           push, pop, full, not_empty;

    bgd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .q_full   (full),
        .q_push   (push),
        .q_data   (push_data)
    );

    bgd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    bgd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (not_empty),
        .q_data   (head),
        .q_pop    (pop),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

[rtl/bgd_checker.sv]
// Port-level checks for the density evaluator, bound to the top level.
`default_nettype none

module bgd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 24'd0)
        else $error("invalid covariance with nonzero density");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind bivariate_gaussian_density bgd_checker u_bgd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

[tb/bivariate_gaussian_density_test.sv]
// Self-checking testbench for the bivariate Gaussian density evaluator.
`timescale 1ns / 1ps
`default_nettype none

module bivariate_gaussian_density_test;

    localparam int          CYCLE_LIMIT    = 600000;
    localparam int          SETTLE_CYCLES  = 100;
    localparam logic [2:0]  CFG_SPARE_LAST = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    bivariate_gaussian_density dut (.*);

    typedef struct packed {
        logic [23:0] density;
        logic        invalid;
    } density_word_t;

    density_word_t      expected_q[$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int                 rx_hold = 0;

    logic signed [15:0] mean_x_r, mean_y_r, cov_xy_r;
    logic [15:0]        var_x_r, var_y_r;
    longint unsigned    frac_pow[17];

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint unsigned sqrt_floor(input longint unsigned v_in);
        longint unsigned v, res, b;
        v   = v_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic density_word_t predict_density(input logic [15:0] px, input logic [15:0] py);
        density_word_t   w;
        longint          dx, dy, vx, vy, c, det, num;
        longint unsigned udet, h, t, f, e, s, d;
        int              n;
        dx  = longint'($signed(px)) - longint'(mean_x_r);
        dy  = longint'($signed(py)) - longint'(mean_y_r);
        vx  = longint'({48'd0, var_x_r});
        vy  = longint'({48'd0, var_y_r});
        c   = longint'(cov_xy_r);
        det = vx * vy - c * c;
        w   = '0;
        if (det <= 0) begin
            w.invalid = 1'b1;
            return w;
        end
        udet = det;
        num  = vy * dx * dx - 2 * c * dx * dy + vx * dy * dy;
        if (num < 0) num = 0;
        h = ((longint'(num) << 7) + (udet >> 1)) / udet;
        e = 0;
        if (h < (64'd64 << 16)) begin
            t = (h * 64'd1549082005 + (64'd1 << 29)) >> 30;
            n = int'(t >> 16);
            f = t & 64'hFFFF;
            e = 64'd1 << 32;
            for (int k = 1; k <= 16; k++) begin
                if (f[16 - k]) e = (e * frac_pow[k] + (64'd1 << 31)) >> 32;
            end
            if (n >= 40) e = 0;
            else if (n > 0) e = (e + (64'd1 << (n - 1))) >> n;
        end
        s = sqrt_floor(udet << 16);
        d = (e * 64'd683565276 + (s << 27)) / (s << 28);
        w.density = (d > 64'hFFFFFF) ? 24'hFFFFFF : d[23:0];
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        density_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata !== want.density) report_mismatch("density", m_tdata, want.density);
                if (m_tuser !== want.invalid) report_mismatch("invalid", m_tuser, want.invalid);
            end
        end
    end

    task automatic send_point(input logic [15:0] px, input logic [15:0] py);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(predict_density(px, py));
        gap = 0;
        if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bgd_pkg::CFG_MEAN_X: mean_x_r = value;
            bgd_pkg::CFG_MEAN_Y: mean_y_r = value;
            bgd_pkg::CFG_VAR_X:  var_x_r  = value;
            bgd_pkg::CFG_VAR_Y:  var_y_r  = value;
            bgd_pkg::CFG_COV_XY: cov_xy_r = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] mx, input logic [15:0] my,
                              input logic [15:0] vx, input logic [15:0] vy,
                              input logic [15:0] c);
        wait_idle();
        write_reg(bgd_pkg::CFG_MEAN_X, mx);
        write_reg(bgd_pkg::CFG_MEAN_Y, my);
        write_reg(bgd_pkg::CFG_VAR_X, vx);
        write_reg(bgd_pkg::CFG_VAR_Y, vy);
        write_reg(bgd_pkg::CFG_COV_XY, c);
    endtask

    task automatic test_directed();
        send_point(16'h0000, 16'h0000);
        send_point(16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000);
        send_point(16'h8000, 16'h7FFF);
        send_point(16'h0100, 16'hFF00);
        send_point(16'h0300, 16'h0000);
        // spare indexes must not disturb anything
        wait_idle();
        for (logic [3:0] i = 4'(bgd_pkg::CFG_COV_XY) + 4'd1; i <= {1'b0, CFG_SPARE_LAST}; i++)
            write_reg(i[2:0], 16'hFFFF);
        send_point(16'h0080, 16'h0040);
        // narrow peak saturates
        set_config(16'h0000, 16'h0000, 16'd1, 16'd1, 16'd0);
        send_point(16'h0000, 16'h0000);
        send_point(16'h0001, 16'h0000);
        // zero and negative determinant
        set_config(16'h0000, 16'h0000, 16'd0, 16'd256, 16'd0);
        send_point(16'h0000, 16'h0000);
        set_config(16'h0000, 16'h0000, 16'd256, 16'd256, 16'h7FFF);
        send_point(16'h0100, 16'h0100);
        set_config(16'h0000, 16'h0000, 16'd256, 16'd256, 16'h8000);
        send_point(16'h0100, 16'h0100);
        // register extremes, far tail
        set_config(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_point(16'h8000, 16'h7FFF);
        send_point(16'h7FFF, 16'h8000);
        set_config(16'h8000, 16'h7FFF, 16'd16, 16'd16, 16'hFFF8);
        send_point(16'h7FFF, 16'h8000);
        send_point(16'h8000, 16'h7FFF);
        send_point(16'h8010, 16'h7FF0);
        set_config(16'h0000, 16'h0000, 16'hFFFF, 16'd1, 16'd255);
        send_point(16'h0000, 16'h0000);
        send_point(16'h4000, 16'h0002);
    endtask

    task automatic random_config();
        logic [15:0] vx, vy, lim;
        logic signed [15:0] c;
        vx = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4, 4096));
        vy = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4, 4096));
        lim = (vx < vy) ? vx : vy;
        if (lim > 16'h7FFF) lim = 16'h7FFF;
        case ($urandom_range(5))
            0: c = '0;
            1: c = 16'($urandom);
            default: c = 16'($signed(16'($urandom_range(0, lim))) * ($urandom_range(1) ? 1 : -1));
        endcase
        set_config(16'($urandom), 16'($urandom), vx, vy, c);
    endtask

    task automatic random_points(input int count);
        int sx, sy;
        sx = (var_x_r < 64) ? 64 : int'(var_x_r);
        sy = (var_y_r < 64) ? 64 : int'(var_y_r);
        if (sx > 4096) sx = 4096;
        if (sy > 4096) sy = 4096;
        repeat (count) begin
            if ($urandom_range(9) < 7)
                send_point(16'(int'(mean_x_r) + $signed($urandom_range(0, 2 * sx)) - sx),
                           16'(int'(mean_y_r) + $signed($urandom_range(0, 2 * sy)) - sy));
            else
                send_point(16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (4) begin
            random_config();
            random_points(130);
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_idle();
        rx_hold = 300;
        random_points(120);
    endtask

    initial begin
        mean_x_r = 0;
        mean_y_r = 0;
        var_x_r  = 16'd256;
        var_y_r  = 16'd256;
        cov_xy_r = 0;
        frac_pow[0] = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) frac_pow[k] = sqrt_floor(frac_pow[k - 1] << 32);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phase(16, 79);
        test_random_phase(79, 16);
        test_random_phase(0, 0);
        test_backpressure();

        wait_idle();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/bgd_pkg.sv
rtl/bgd_cfg.sv
rtl/bgd_front.sv
rtl/bgd_fifo.sv
rtl/bgd_back.sv
rtl/bivariate_gaussian_density.sv
rtl/bgd_checker.sv
tb/bivariate_gaussian_density_test.sv
